### rtl/core/assert_macros.svh
// Assertion macros shared by the timer RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer assertion failed");

`endif

### rtl/core/lapic_tmr_pkg.sv
// Constants, codes and helper functions of the local APIC countdown timer.
// No dependencies.
package lapic_tmr_pkg;

    // Counter width (8 to 32)
    localparam int COUNT_WIDTH = 32;

    // Item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Register selects
    localparam logic [1:0] SEL_VECTOR  = 2'd0;
    localparam logic [1:0] SEL_INITIAL = 2'd1;
    localparam logic [1:0] SEL_CURRENT = 2'd2;
    localparam logic [1:0] SEL_DIVIDE  = 2'd3;

    // Timer modes
    localparam logic [1:0] MODE_PERIODIC = 2'd1;

    // Writable bits of the divide code
    localparam logic [3:0] DIVIDE_BITS = 4'hB;

    // Packed widths of the stream payloads
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 4;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 1;

    // Divisor from the divide code: index bit3:bit1:bit0, 7 means divide by 1
    function automatic logic [7:0] divisor_of(input logic [3:0] code);
        logic [2:0] idx;
        idx = {code[3], code[1:0]};
        if (idx == 3'd7)
            return 8'd1;
        return 8'd2 << idx;
    endfunction

endpackage

### rtl/core/local_apic_countdown_timer.sv
// Local APIC countdown timer: tick / register access stream in, result stream out.
// Depends on lapic_tmr_pkg and assert_macros.svh.
//
//  channel | direction | tdata                          | tuser
//  --------+-----------+--------------------------------+------------------------
//  s_*     | in        | wdata[31:0]                    | kind[1:0], reg_sel[3:2]
//  m_*     | out       | rdata[31:0], irq_vector[39:32] | irq_fire[0]
//
// One transfer can be taken in every clock cycle while s_tready is high. The timer state
// updates at the transfer edge, and the result is captured at that same edge, in the
// output register if it is free or being drained, else in the skid stage.
// An output register plus one skid stage decouple the two sides; s_tready drops
// only while the skid stage holds a result.
// rst_n clears all control and timer state asynchronously (entry masked,
// one-shot, counter stopped, divide by two).
`include "assert_macros.svh"

module local_apic_countdown_timer
    import lapic_tmr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // wdata[31:0]
    input  logic [S_USER_W-1:0] s_tuser,   // kind[1:0], reg_sel[3:2]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // rdata[31:0], irq_vector[39:32]
    output logic [M_USER_W-1:0] m_tuser    // irq_fire[0]
);

    // Timer state
    logic [7:0]             timer_vector_reg, timer_vector_next;
    logic                   timer_masked_reg, timer_masked_next;
    logic [1:0]             timer_mode_reg, timer_mode_next;
    logic [COUNT_WIDTH-1:0] reload_count_reg, reload_count_next;
    logic [COUNT_WIDTH-1:0] live_count_reg, live_count_next;
    logic [3:0]             divide_code_reg, divide_code_next;
    logic [6:0]             prescale_count_reg, prescale_count_next;

    // Output register and skid stage
    logic                   out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0]    out_data_reg, out_data_next;
    logic                   out_fire_reg, out_fire_next;
    logic                   skid_valid_reg, skid_valid_next;
    logic [M_DATA_W-1:0]    skid_data_reg, skid_data_next;
    logic                   skid_fire_reg, skid_fire_next;

    // Decoded input and result of the current item
    logic                   s_accept;
    logic [1:0]             kind;
    logic [1:0]             reg_sel;
    logic [31:0]            wdata;
    logic [31:0]            res_rdata;
    logic                   res_fire;
    logic [7:0]             res_vector;
    logic [M_DATA_W-1:0]    res_data;
    logic [7:0]             prescale_inc;
    logic [COUNT_WIDTH-1:0] live_dec;
    logic                   load_initial;

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign kind     = s_tuser[1:0];
    assign reg_sel  = s_tuser[3:2];
    assign wdata    = s_tdata[31:0];

    assign load_initial = s_accept && kind == KIND_WRITE && reg_sel == SEL_INITIAL;

    assign prescale_inc = {1'b0, prescale_count_reg} + 8'd1;
    assign live_dec     = live_count_reg - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    // Per-item timer update and result
    always_comb
    begin
        timer_vector_next   = timer_vector_reg;
        timer_masked_next   = timer_masked_reg;
        timer_mode_next     = timer_mode_reg;
        reload_count_next   = reload_count_reg;
        live_count_next     = live_count_reg;
        divide_code_next    = divide_code_reg;
        prescale_count_next = prescale_count_reg;
        res_rdata           = 32'd0;
        res_fire            = 1'b0;
        res_vector          = 8'd0;
        case (kind)
            KIND_TICK:
            begin
                if (live_count_reg != '0)
                begin
                    if (prescale_inc >= divisor_of(divide_code_reg))
                    begin
                        prescale_count_next = 7'd0;
                        live_count_next     = live_dec;
                        if (live_dec == '0)
                        begin
                            if (!timer_masked_reg)
                            begin
                                res_fire   = 1'b1;
                                res_vector = timer_vector_reg;
                            end
                            if (timer_mode_reg == MODE_PERIODIC)
                                live_count_next = reload_count_reg;
                        end
                    end
                    else
                    begin
                        prescale_count_next = prescale_inc[6:0];
                    end
                end
            end
            KIND_WRITE:
            begin
                case (reg_sel)
                    SEL_VECTOR:
                    begin
                        timer_vector_next = wdata[7:0];
                        timer_masked_next = wdata[16];
                        timer_mode_next   = wdata[18:17];
                    end
                    SEL_INITIAL:
                    begin
                        reload_count_next   = wdata[COUNT_WIDTH-1:0];
                        live_count_next     = wdata[COUNT_WIDTH-1:0];
                        prescale_count_next = 7'd0;
                    end
                    SEL_CURRENT:
                    begin
                        // read only
                    end
                    default:
                    begin
                        divide_code_next = wdata[3:0] & DIVIDE_BITS;
                    end
                endcase
            end
            KIND_READ:
            begin
                case (reg_sel)
                    SEL_VECTOR:
                        res_rdata = {13'd0, timer_mode_reg, timer_masked_reg, 8'd0,
                                     timer_vector_reg};
                    SEL_INITIAL:
                        res_rdata = 32'(reload_count_reg);
                    SEL_CURRENT:
                        res_rdata = 32'(live_count_reg);
                    default:
                        res_rdata = {28'd0, divide_code_reg};
                endcase
            end
            default:
            begin
                // unused kind: no effect, zero result
            end
        endcase
    end

    assign res_data = {res_vector, res_rdata};

    // Output register / skid stage steering
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_fire_next   = out_fire_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_fire_next  = skid_fire_reg;
        if (s_accept)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res_data;
                out_fire_next  = res_fire;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res_data;
                skid_fire_next  = res_fire;
            end
        end
        else if (out_valid_reg && m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_fire_next   = skid_fire_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // Control and timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_vector_reg   <= 8'd0;
            timer_masked_reg   <= 1'b1;
            timer_mode_reg     <= 2'd0;
            reload_count_reg   <= '0;
            live_count_reg     <= '0;
            divide_code_reg    <= 4'd0;
            prescale_count_reg <= 7'd0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                timer_vector_reg   <= timer_vector_next;
                timer_masked_reg   <= timer_masked_next;
                timer_mode_reg     <= timer_mode_next;
                reload_count_reg   <= reload_count_next;
                live_count_reg     <= live_count_next;
                divide_code_reg    <= divide_code_next;
                prescale_count_reg <= prescale_count_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_fire_reg  <= out_fire_next;
        skid_data_reg <= skid_data_next;
        skid_fire_reg <= skid_fire_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_fire_reg;

    // Checks
    `ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `ASSERT_IMPL(a_fire_no_rdata, m_tvalid && m_tuser[0], m_tdata[31:0] == 32'd0)
    `ASSERT_NEXT(a_initial_loads, load_initial, live_count_reg == $past(wdata[COUNT_WIDTH-1:0]))
    `ASSERT_NEXT(a_initial_clears_prescale, load_initial, prescale_count_reg == 7'd0)

endmodule
